@@ src/pprt_pkg.sv @@
package pprt_pkg;

    localparam int RULE_ENTRIES = 64;
    localparam int CNT_W        = $clog2(RULE_ENTRIES);
    localparam int ADDR_W       = 32;
    localparam int PORT_W       = 32;
    localparam int MASK_W       = 6;
    localparam int MODE_W       = 4;
    localparam int HALF_W       = 16;
    localparam int KEY_W        = MASK_W + 1;
    localparam logic [MASK_W-1:0] FULL_MASK = MASK_W'(32);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_DEL    = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [MASK_W-1:0] mask;
        logic [PORT_W-1:0] port;
        logic [MODE_W-1:0] mode;
    } t_rule;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [MASK_W-1:0] mask;
        logic [MODE_W-1:0] mode;
    } t_query;

    // best lookup hit so far plus exact-match flag, passed down the chain
    typedef struct packed {
        logic              found;
        logic [KEY_W-1:0]  key;
        logic [MODE_W-1:0] mode;
        logic              seen;
    } t_wave;

    typedef struct packed {
        logic add;
        logic del;
    } t_ctrl;

endpackage

@@ src/pprt_if.sv @@
interface pprt_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         operation;
    logic [pprt_pkg::ADDR_W-1:0]        dest_address;
    logic [pprt_pkg::PORT_W-1:0]        port_code;
    logic [pprt_pkg::MASK_W-1:0]        mask_bits;
    logic [pprt_pkg::MODE_W-1:0]        dump_mode;
    modport source(output valid, operation, dest_address, port_code, mask_bits, dump_mode,
                   input ready);
    modport sink(input valid, operation, dest_address, port_code, mask_bits, dump_mode,
                 output ready);
endinterface

interface pprt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [pprt_pkg::MODE_W-1:0] found_mode;
    modport source(output valid, status, found_mode, input ready);
    modport sink(input valid, status, found_mode, output ready);
endinterface

@@ src/pprt_cell.sv @@
module pprt_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pprt_pkg::t_query i_query,
    input  pprt_pkg::t_ctrl  i_ctrl,
    input  logic             i_prev_valid,
    input  pprt_pkg::t_wave  i_prev_wave,
    input  logic             i_next_valid,
    input  pprt_pkg::t_rule  i_next_rule,
    output logic             o_valid,
    output pprt_pkg::t_rule  o_rule,
    output pprt_pkg::t_wave  o_wave
);

    logic                          r_valid;
    pprt_pkg::t_rule               r_rule;
    pprt_pkg::t_wave               r_wave;
    pprt_pkg::t_wave               n_wave;
    logic                          is_range;
    logic [pprt_pkg::ADDR_W-1:0]   mask_vec;
    logic                          port_hit;
    logic                          own_hit;
    logic                          own_exact;
    logic [pprt_pkg::KEY_W-1:0]    own_key;
    logic [pprt_pkg::PORT_W-1:0]   lo_port;
    logic [pprt_pkg::PORT_W-1:0]   hi_port;

    always_comb begin
        is_range = |r_rule.port[pprt_pkg::PORT_W-1:pprt_pkg::HALF_W];
        lo_port  = {{pprt_pkg::HALF_W{1'b0}}, r_rule.port[pprt_pkg::HALF_W-1:0]};
        hi_port  = {{pprt_pkg::HALF_W{1'b0}},
                    r_rule.port[pprt_pkg::PORT_W-1:pprt_pkg::HALF_W]};
        mask_vec = r_rule.mask[5] ? '0 : ~((32'd1 << r_rule.mask[4:0]) - 32'd1);
        if (is_range) begin
            port_hit = (i_query.port >= lo_port) && (i_query.port <= hi_port);
        end else begin
            port_hit = (i_query.port == r_rule.port);
        end
        own_hit   = r_valid && (r_rule.mask <= pprt_pkg::FULL_MASK) &&
                    ((i_query.addr & mask_vec) == r_rule.addr) && port_hit;
        own_key   = {is_range, r_rule.mask};
        own_exact = r_valid && (r_rule.addr == i_query.addr) &&
                    (r_rule.mask == i_query.mask) && (r_rule.port == i_query.port);

        // earlier row keeps the win on equal key
        if (i_prev_wave.found && (!own_hit || i_prev_wave.key <= own_key)) begin
            n_wave.found = 1'b1;
            n_wave.key   = i_prev_wave.key;
            n_wave.mode  = i_prev_wave.mode;
        end else begin
            n_wave.found = own_hit;
            n_wave.key   = own_key;
            n_wave.mode  = r_rule.mode;
        end
        n_wave.seen = i_prev_wave.seen | own_exact;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wave  <= '0;
        end else begin
            r_wave <= n_wave;
            if (i_ctrl.del && r_wave.seen) begin
                r_valid <= i_next_valid;
            end else if (i_ctrl.add && !r_valid && i_prev_valid) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.del && r_wave.seen) begin
            r_rule <= i_next_rule;
        end else if (i_ctrl.add && !r_valid && i_prev_valid) begin
            r_rule <= '{addr: i_query.addr, mask: i_query.mask,
                        port: i_query.port, mode: i_query.mode};
        end
    end

    assign o_valid = r_valid;
    assign o_rule  = r_rule;
    assign o_wave  = r_wave;

endmodule

@@ src/prefix_port_rule_table_core.sv @@
// prefix and port rule table
//
// request channel i_req: operation (lookup, add rule, delete rule), address,
// port code, mask count and dump mode. response channel o_rsp: status and
// found mode, one response per request, in request order.
// rules sit in a row of cells, one rule per cell, packed from cell 0 in
// insertion order. after a request is taken the query is held and a wave
// moves down the row one cell per cycle, carrying the best lookup hit
// (exact rules before range rules, longest prefix first, earliest row on a
// tie) and a flag for an exact rule match. when the sweep ends the last
// cell holds the answer; the commit step then applies the add or the
// delete (cells at and after the deleted row load from their neighbor).
// a new request is taken only after the last one has left the commit
// step: i_req.ready is high whenever no request is in work, so a request
// can be taken while a response still waits in the output register; a
// stalled receiver holds the next response in the commit step.
// reset empties the table and drops any request or response in flight.
module prefix_port_rule_table_core (
    input logic       i_clk,
    input logic       i_rst_n,
    pprt_req_if.sink   i_req,
    pprt_rsp_if.source o_rsp
);

    localparam int N = pprt_pkg::RULE_ENTRIES;

    pprt_pkg::t_state                 r_state;
    pprt_pkg::t_state                 n_state;
    logic [pprt_pkg::CNT_W-1:0]       r_cnt;
    pprt_pkg::t_query                 r_query;
    logic                             r_out_valid;
    logic                             r_status;
    logic [pprt_pkg::MODE_W-1:0]      r_mode;

    logic                             req_take;
    logic                             slot_free;
    logic                             sweep_done;
    logic                             commit;
    pprt_pkg::t_ctrl                  ctrl;
    logic                             dup;
    logic                             full;
    logic                             res_status;
    logic [pprt_pkg::MODE_W-1:0]      res_mode;

    logic             cell_valid [N];
    pprt_pkg::t_rule  cell_rule  [N];
    pprt_pkg::t_wave  cell_wave  [N];
    logic [N-1:0]     valid_vec;

    assign req_take   = i_req.valid && i_req.ready;
    assign slot_free  = !r_out_valid || o_rsp.ready;
    assign sweep_done = (r_cnt == pprt_pkg::CNT_W'(N - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pprt_pkg::ST_IDLE:  if (req_take) n_state = pprt_pkg::ST_SWEEP;
            pprt_pkg::ST_SWEEP: if (sweep_done) n_state = pprt_pkg::ST_APPLY;
            pprt_pkg::ST_APPLY: if (slot_free) n_state = pprt_pkg::ST_IDLE;
            default:            n_state = pprt_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready = 1'b0;
        commit      = 1'b0;
        unique case (r_state)
            pprt_pkg::ST_IDLE:  i_req.ready = 1'b1;
            pprt_pkg::ST_SWEEP: ;
            pprt_pkg::ST_APPLY: commit = slot_free;
            default:            ;
        endcase
    end

    // result from the tail of the chain
    always_comb begin
        dup        = cell_wave[N-1].seen;
        full       = cell_valid[N-1];
        ctrl.add   = commit && (r_query.op == pprt_pkg::OP_ADD) && !dup;
        ctrl.del   = commit && (r_query.op == pprt_pkg::OP_DEL) && dup;
        res_status = 1'b1;
        res_mode   = '0;
        unique case (r_query.op)
            pprt_pkg::OP_LOOKUP: begin
                res_status = !cell_wave[N-1].found;
                res_mode   = cell_wave[N-1].found ? cell_wave[N-1].mode : '0;
            end
            pprt_pkg::OP_ADD:  res_status = dup || full;
            pprt_pkg::OP_DEL:  res_status = !dup;
            default:           res_status = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pprt_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pprt_pkg::ST_SWEEP) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_query <= '{op: pprt_pkg::t_op'(i_req.operation), addr: i_req.dest_address,
                         port: i_req.port_code, mask: i_req.mask_bits,
                         mode: i_req.dump_mode};
        end
        if (commit) begin
            r_status <= res_status;
            r_mode   <= res_mode;
        end
    end

    // row of rule cells
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            logic            prev_valid;
            pprt_pkg::t_wave prev_wave;
            logic            next_valid;
            pprt_pkg::t_rule next_rule;
            if (gi == 0) begin : g_head
                assign prev_valid = 1'b1;
                assign prev_wave  = '0;
            end else begin : g_body
                assign prev_valid = cell_valid[gi-1];
                assign prev_wave  = cell_wave[gi-1];
            end
            if (gi == N - 1) begin : g_tail
                assign next_valid = 1'b0;
                assign next_rule  = cell_rule[gi];
            end else begin : g_mid
                assign next_valid = cell_valid[gi+1];
                assign next_rule  = cell_rule[gi+1];
            end
            pprt_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_query      (r_query),
                .i_ctrl       (ctrl),
                .i_prev_valid (prev_valid),
                .i_prev_wave  (prev_wave),
                .i_next_valid (next_valid),
                .i_next_rule  (next_rule),
                .o_valid      (cell_valid[gi]),
                .o_rule       (cell_rule[gi]),
                .o_wave       (cell_wave[gi])
            );
            assign valid_vec[gi] = cell_valid[gi];
        end
    endgenerate

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.found_mode = r_mode;

    // occupied cells stay packed from cell 0
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("rule cells not packed");

    // a failed request never reports a mode
    a_err_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |-> (o_rsp.found_mode == '0))
        else $error("mode on error response");

    // commit always leaves a response in the output register
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (o_rsp.valid && r_state == pprt_pkg::ST_IDLE))
        else $error("response lost at commit");

    // a sweep never falls back to idle before it is done
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pprt_pkg::ST_SWEEP) |=> !(r_state == pprt_pkg::ST_IDLE && !sweep_done &&
        $past(!sweep_done)))
        else $error("sweep cut short");

endmodule
